// ----- rtl/core/cas_pkg.sv -----
// Shared opcodes, status codes and controller/datapath interface types.
`timescale 1ns / 1ps

package cas_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_APPEND = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_READ   = 2'd2;
   localparam op_type OP_WRITE  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic eval;
      logic append;
      logic write;
      logic read_issue;
      logic shift_start;
      logic shift_step;
      logic dec_count;
      logic capture_read;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      op_type op;
      logic   full;
      logic   range_err;
      logic   shift_needed;
      logic   shift_more;
      logic   rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/core/compacting_array_store.sv -----
// Top level of the compacting array store: controller plus datapath.
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY elements held in a single-port-write, registered-read
// RAM. One item is handled at a time and gives one result. Append, write and out-of-range
// or full requests go from the execute state straight to the done state, read passes through
// a read-wait state first, and the done state loads the result register once it is free.
// Removing index i from n stored elements moves the n-i-1 later elements down one place per
// cycle, as the RAM allows one read and one write each cycle. The next item is taken in the
// cycle after the result register is loaded, even if the previous result has not yet been taken.
module compacting_array_store
   import cas_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  op_type                req_opcode,
   input  logic [IDX_W-1:0]      req_index,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic [CNT_W-1:0]      rsp_element_count,
   output status_type            rsp_status
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cas_dpath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- rtl/core/cas_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module cas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cas_dpath.sv -----
// Datapath: request registers, element count, shift pointer, element RAM and result register.
`timescale 1ns / 1ps

module cas_dpath
   import cas_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  op_type                req_opcode,
   input  logic [IDX_W-1:0]      req_index,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic [CNT_W-1:0]      rsp_element_count,
   output status_type            rsp_status
);

   localparam int CMP_W = CNT_W + 1;

   op_type                op_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [VALUE_BITS-1:0] rd_ff, rd_in;
   status_type            st_ff, st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   status_type            rsp_status_ff;

   logic                  wr_en, rd_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data, ram_rdata;
   logic                  full, range_err;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign range_err = (CNT_W'(idx_ff) >= count_ff);

   always_comb begin
      status.op           = op_ff;
      status.full         = full;
      status.range_err    = range_err;
      status.shift_needed = (CMP_W'(idx_ff) + CMP_W'(1)) < CMP_W'(count_ff);
      status.shift_more   = (CMP_W'(ptr_ff) + CMP_W'(2)) < CMP_W'(count_ff);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // RAM port steering; during a shift the element read last cycle lands one place lower.
   always_comb begin
      wr_en = cmd.append || cmd.write || cmd.shift_step;
      if (cmd.shift_step) begin
         wr_addr = ptr_ff;
         wr_data = ram_rdata;
      end else if (cmd.append) begin
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = val_ff;
      end else begin
         wr_addr = idx_ff;
         wr_data = val_ff;
      end

      rd_en = cmd.read_issue || cmd.shift_start || (cmd.shift_step && status.shift_more);
      if (cmd.read_issue) begin
         rd_addr = idx_ff;
      end else if (cmd.shift_start) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else begin
         rd_addr = ptr_ff + IDX_W'(2);
      end
   end

   cas_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end

      ptr_in = ptr_ff;
      if (cmd.shift_start) begin
         ptr_in = idx_ff;
      end else if (cmd.shift_step) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end

      rd_in = rd_ff;
      st_in = st_ff;
      if (cmd.eval) begin
         rd_in = '0;
         if (op_ff == OP_APPEND) begin
            st_in = full ? ST_FULL : ST_OK;
         end else begin
            st_in = range_err ? ST_RANGE : ST_OK;
         end
      end else if (cmd.capture_read) begin
         rd_in = ram_rdata;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      ptr_ff <= ptr_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
      if (cmd.load_rsp) begin
         rsp_value_ff  <= rd_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= st_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- rtl/core/cas_ctrl.sv -----
// Controller state machine sequencing each item through the datapath.
`timescale 1ns / 1ps

module cas_ctrl
   import cas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.eval = 1'b1;
            state_in = S_DONE;
            if (status.op == OP_APPEND) begin
               cmd.append = !status.full;
            end else if (!status.range_err) begin
               case (status.op)
                  OP_REMOVE: begin
                     if (status.shift_needed) begin
                        cmd.shift_start = 1'b1;
                        state_in        = S_SHIFT;
                     end else begin
                        cmd.dec_count = 1'b1;
                     end
                  end
                  OP_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = S_RDWAIT;
                  end
                  OP_WRITE: begin
                     cmd.write = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = S_DONE;
         end
         S_SHIFT: begin
            // The element at the pointer is overwritten by its upper neighbour each cycle.
            cmd.shift_step = 1'b1;
            if (!status.shift_more) begin
               cmd.dec_count = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- dv/compacting_array_store_tb.sv -----
// Self-checking testbench for the compacting array store: predictor, stimulus and checks.
`timescale 1ns / 1ps

module compacting_array_store_tb;
   import cas_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int TOTAL_ITEMS = 1800;
   localparam int PHASE_ITEMS = 600;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic [VALUE_BITS-1:0] read_value;
      logic [CNT_W-1:0]      element_count;
      status_type            status;
   } store_result_type;

   typedef enum {GROW_TRAFFIC, SHRINK_TRAFFIC, MIXED_TRAFFIC} traffic_mode_type;

   // Mirrors the store contents and queues the result each accepted item should give.
   class element_store_tracker;
      logic [VALUE_BITS-1:0] elements [CAPACITY];
      int unsigned           count;
      store_result_type      expected_results [$];
      int unsigned           failures;

      function void note_request(op_type op, logic [IDX_W-1:0] idx,
                                 logic [VALUE_BITS-1:0] val);
         store_result_type r;
         r.read_value = '0;
         r.status     = ST_OK;
         if (op == OP_APPEND) begin
            if (count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               elements[count] = val;
               count++;
            end
         end else if (idx >= count) begin
            r.status = ST_RANGE;
         end else if (op == OP_REMOVE) begin
            for (int i = idx; i + 1 < count; i++)
               elements[i] = elements[i + 1];
            count--;
         end else if (op == OP_READ) begin
            r.read_value = elements[idx];
         end else begin
            elements[idx] = val;
         end
         r.element_count = CNT_W'(count);
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [VALUE_BITS-1:0] rd, logic [CNT_W-1:0] cnt,
                                 status_type st);
         store_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result: read_value %h element_count %0d status %0d",
                   rd, cnt, st);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (rd !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rd);
            failures++;
         end
         if (cnt !== want.element_count) begin
            $error("element_count: expected %0d, got %0d", want.element_count, cnt);
            failures++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   op_type                req_opcode = OP_APPEND;
   logic [IDX_W-1:0]      req_index  = '0;
   logic [VALUE_BITS-1:0] req_value  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [VALUE_BITS-1:0] rsp_read_value;
   logic [CNT_W-1:0]      rsp_element_count;
   status_type            rsp_status;

   element_store_tracker tracker = new();
   int unsigned          items_sent    = 0;
   int unsigned          send_idle_pct = 17;
   int unsigned          recv_idle_pct = 64;

   compacting_array_store #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   // Results are checked against the values held before the edge; ready is redrawn each cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_read_value, rsp_element_count, rsp_status);
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic [VALUE_BITS-1:0] val);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_index  <= idx;
      req_value  <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(op, idx, val);
      items_sent++;
      if (items_sent == PHASE_ITEMS) begin
         send_idle_pct = 64;
         recv_idle_pct = 17;
      end else if (items_sent == 2 * PHASE_ITEMS) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return VALUE_BITS'($urandom);
   endfunction

   // Mostly indices that hit a stored element, with a lean towards the head for long shifts.
   function automatic logic [IDX_W-1:0] pick_index();
      if (tracker.count != 0 && $urandom_range(0, 99) < 80) begin
         if ($urandom_range(0, 7) == 0) return '0;
         return IDX_W'($urandom_range(0, tracker.count - 1));
      end
      return IDX_W'($urandom_range(0, CAPACITY - 1));
   endfunction

   function automatic op_type pick_opcode(traffic_mode_type mode);
      int unsigned roll;
      int unsigned append_below;
      int unsigned remove_below;
      roll = $urandom_range(0, 99);
      case (mode)
         GROW_TRAFFIC: begin
            append_below = 55;
            remove_below = 65;
         end
         SHRINK_TRAFFIC: begin
            append_below = 10;
            remove_below = 65;
         end
         default: begin
            append_below = 30;
            remove_below = 55;
         end
      endcase
      if (roll < append_below) return OP_APPEND;
      if (roll < remove_below) return OP_REMOVE;
      if (roll < remove_below + (100 - remove_below) / 2) return OP_READ;
      return OP_WRITE;
   endfunction

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("compacting_array_store regression: fail");
      $finish;
   end

   initial begin : stimulus
      traffic_mode_type mode;
      bit               fill_next;
      int unsigned      burst_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Every read, remove and write against an empty store lands out of range.
      send_item(OP_READ,   '0, '0);
      send_item(OP_REMOVE, '0, '1);
      send_item(OP_WRITE,  '0, 32'hDEAD_BEEF);
      send_item(OP_READ,   '1, '0);
      send_item(OP_APPEND, '0, '0);
      send_item(OP_APPEND, '1, '1);
      send_item(OP_APPEND, 6'h2A, 32'hA5A5_A5A5);
      send_item(OP_READ,   6'd0, '0);
      send_item(OP_READ,   6'd1, '0);
      send_item(OP_READ,   6'd2, '1);
      send_item(OP_WRITE,  6'd1, 32'h1234_5678);
      send_item(OP_READ,   6'd1, '0);
      send_item(OP_READ,   6'd3, '0);
      send_item(OP_WRITE,  6'd3, 32'h5555_5555);
      send_item(OP_REMOVE, 6'd0, '0);
      send_item(OP_READ,   6'd0, '0);
      send_item(OP_READ,   6'd1, '0);
      send_item(OP_REMOVE, 6'd1, '0);
      send_item(OP_REMOVE, 6'd0, '0);
      send_item(OP_READ,   6'd0, '0);
      send_item(OP_APPEND, '1, 32'h8000_0001);
      send_item(OP_WRITE,  '1, '0);

      // Random traffic in bursts that grow, drain or churn the store; a fill to capacity
      // followed by appends against the full store opens the run and recurs now and then.
      fill_next = 1'b1;
      while (items_sent < TOTAL_ITEMS) begin
         if (fill_next) begin
            while (tracker.count < CAPACITY)
               send_item(OP_APPEND, IDX_W'($urandom), random_value());
            repeat (2) send_item(OP_APPEND, IDX_W'($urandom), random_value());
            send_item(OP_READ, IDX_W'(CAPACITY - 1), random_value());
            send_item(OP_WRITE, IDX_W'(CAPACITY - 1), random_value());
         end
         mode      = traffic_mode_type'($urandom_range(0, 2));
         burst_len = $urandom_range(20, 100);
         repeat (burst_len)
            send_item(pick_opcode(mode), pick_index(), random_value());
         fill_next = ($urandom_range(0, 5) == 0);
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (CAPACITY + 16) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("compacting_array_store regression: pass");
      else
         $display("compacting_array_store regression: fail");
      $finish;
   end

endmodule
